>>> hdl/plid_pkg.sv
// ----------------------------------------------------------------------------
// plid_pkg
// Shared constants, operation codes and controller/datapath interface types
// for the positional list block.
// ----------------------------------------------------------------------------
`default_nettype none

package plid_pkg;

    // list capacity, the index width derived from it, and the other widths
    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = 5;
    localparam int POS_W = 5;
    localparam int VAL_W = 32;
    localparam int OP_W  = 2;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_GET    = 2'd2
    } op_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic commit;
        logic report;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic legal;
    } status_t;

endpackage

`default_nettype wire

>>> hdl/plid_ctrl.sv
// ----------------------------------------------------------------------------
// plid_ctrl
// Sequencing state machine: takes an item, runs an execute state, then
// presents the result for one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module plid_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire plid_pkg::status_t status,
    output plid_pkg::cmd_t         cmd,
    output logic                   busy,
    output logic                   done
);
    import plid_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_RESP = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (start) state_next = S_EXEC;
            S_EXEC: state_next = S_RESP;
            S_RESP: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // commands and handshake outputs
    always_comb
    begin
        cmd.load   = (state_reg == S_IDLE) && start;
        cmd.commit = (state_reg == S_EXEC) && status.legal;
        cmd.report = (state_reg == S_EXEC);
        busy       = (state_reg != S_IDLE);
        done       = (state_reg == S_RESP);
    end

endmodule

`default_nettype wire

>>> hdl/plid_dp.sv
// ----------------------------------------------------------------------------
// plid_dp
// List datapath: a row of shifting cells, the entry count, the latched
// item and the result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module plid_dp (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire plid_pkg::cmd_t                       cmd,
    input  wire logic [plid_pkg::OP_W-1:0]            op,
    input  wire logic [plid_pkg::POS_W-1:0]           position,
    input  wire logic signed [plid_pkg::VAL_W-1:0]    value,
    output plid_pkg::status_t                         status,
    output logic                                      ok,
    output logic signed [plid_pkg::VAL_W-1:0]         read_value,
    output logic [plid_pkg::CNT_W-1:0]                count,
    output logic                                      empty_res,
    output logic                                      full_res
);
    import plid_pkg::*;

    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    logic [OP_W-1:0]          op_reg;
    logic [POS_W-1:0]         pos_reg;
    logic signed [VAL_W-1:0]  val_reg;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic signed [VAL_W-1:0]  cells_reg  [DEPTH];
    logic signed [VAL_W-1:0]  cells_next [DEPTH];
    logic                     ok_reg;
    logic signed [VAL_W-1:0]  rd_reg, rd_next;
    logic                     legal;

    // latch the item
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= op;
            pos_reg <= position;
            val_reg <= value;
        end
    end

    // range check against the current count
    always_comb
    begin
        case (op_reg)
            OP_INSERT: legal = (count_reg < DEPTH_C) && (pos_reg <= count_reg);
            OP_DELETE: legal = (pos_reg < count_reg);
            OP_GET:    legal = (pos_reg < count_reg);
            default:   legal = 1'b0;
        endcase
        status.legal = legal;
    end

    // each cell takes its own value, its lower or upper neighbor, or the new value
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        localparam logic [POS_W-1:0] IDX = POS_W'(i);
        logic signed [VAL_W-1:0] prev_w;
        logic signed [VAL_W-1:0] succ_w;

        if (i == 0)
        begin : g_first
            assign prev_w = cells_reg[i];
        end
        else
        begin : g_mid_lo
            assign prev_w = cells_reg[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign succ_w = cells_reg[i];
        end
        else
        begin : g_mid_hi
            assign succ_w = cells_reg[i+1];
        end

        always_comb
        begin
            cells_next[i] = cells_reg[i];
            if (cmd.commit)
            begin
                case (op_reg)
                    OP_INSERT:
                    begin
                        if (IDX > pos_reg)
                            cells_next[i] = prev_w;
                        else if (IDX == pos_reg)
                            cells_next[i] = val_reg;
                    end
                    OP_DELETE:
                    begin
                        if (IDX >= pos_reg)
                            cells_next[i] = succ_w;
                    end
                    default: cells_next[i] = cells_reg[i];
                endcase
            end
        end

        always_ff @(posedge clk)
        begin
            cells_reg[i] <= cells_next[i];
        end
    end

    // count update
    always_comb
    begin
        count_next = count_reg;
        if (cmd.commit)
        begin
            case (op_reg)
                OP_INSERT: count_next = count_reg + CNT_W'(1);
                OP_DELETE: count_next = count_reg - CNT_W'(1);
                default:   count_next = count_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // read port for get
    always_comb
    begin
        rd_next = '0;
        if (legal && (op_reg == OP_GET))
            rd_next = cells_reg[pos_reg[IDX_W-1:0]];
    end

    // result registers
    always_ff @(posedge clk)
    begin
        if (cmd.report)
        begin
            ok_reg <= legal;
            rd_reg <= rd_next;
        end
    end

    assign ok         = ok_reg;
    assign read_value = rd_reg;
    assign count      = count_reg;
    assign empty_res  = (count_reg == '0);
    assign full_res   = (count_reg == DEPTH_C);

endmodule

`default_nettype wire

>>> hdl/positional_list_insert_delete.sv
// ----------------------------------------------------------------------------
// positional_list_insert_delete
// Ordered list of signed 32-bit values with insert, delete and get by position.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: an item (op, position, value) is taken at a clock edge
//   where start is high and busy is low. busy stays high until the result has
//   been shown.
//   Result channel: done is high for exactly one cycle; ok, read_value, count,
//   empty_res and full_res are valid in that cycle only. The receiver cannot
//   stall, so the result is simply dropped after that cycle.
//   Sequence: the accepting edge moves the controller to its execute state, in
//   which every cell shifts toward or away from its neighbor in parallel and
//   the result registers are loaded; done is raised in the response state
//   that follows. A new item can be taken in the cycle after done, not before.
//   Rejected operations leave the list unchanged and report ok low with
//   read_value zero and the current count.
//   Reset: asynchronous, active low; the count returns to zero, so the list
//   is empty. Cell contents are not cleared and are never read before written.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_insert_delete (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic [plid_pkg::OP_W-1:0]            op,
    input  wire logic [plid_pkg::POS_W-1:0]           position,
    input  wire logic signed [plid_pkg::VAL_W-1:0]    value,
    output logic                                      done,
    output logic                                      ok,
    output logic signed [plid_pkg::VAL_W-1:0]         read_value,
    output logic [plid_pkg::CNT_W-1:0]                count,
    output logic                                      empty_res,
    output logic                                      full_res
);
    import plid_pkg::*;

    cmd_t    cmd;
    status_t status;

    // sequencing
    plid_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // list storage and result
    plid_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .op         (op),
        .position   (position),
        .value      (value),
        .status     (status),
        .ok         (ok),
        .read_value (read_value),
        .count      (count),
        .empty_res  (empty_res),
        .full_res   (full_res)
    );

endmodule

`default_nettype wire

>>> tb/positional_list_insert_delete_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// positional_list_insert_delete_tb
// Drives directed items and then random bursts of insert, delete, get and
// unused-op items into the positional list. A mirror of the list predicts ok,
// read_value, count and the empty/full flags of each item, and every done
// strobe is checked against the oldest prediction.
// ----------------------------------------------------------------------------

module positional_list_insert_delete_tb;

    import plid_pkg::*;

    // op code the block has no operation for
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_NEG1 = '1;

    localparam int ITEMS_PER_PHASE = 250;

    // one predicted result
    typedef struct {
        logic                    ok;
        logic signed [VAL_W-1:0] read_value;
        logic [CNT_W-1:0]        count;
        logic                    empty;
        logic                    full;
    } outcome_t;

    // mirror of the list contents and the queue of predicted results
    class list_mirror;
        logic signed [VAL_W-1:0] cells [DEPTH];
        int unsigned             used;
        outcome_t                pending_outcomes [$];
        int                      errors;

        function new();
            used   = 0;
            errors = 0;
        endfunction

        // apply an accepted item to the mirror and queue its outcome
        function void note_item(logic [OP_W-1:0] o, logic [POS_W-1:0] p,
                                logic signed [VAL_W-1:0] v);
            outcome_t r;
            int       i;
            r.ok         = 1'b0;
            r.read_value = '0;
            case (o)
                OP_INSERT:
                    if (used < DEPTH && p <= used)
                    begin
                        for (i = used; i > p; i--)
                            cells[i] = cells[i-1];
                        cells[p] = v;
                        used++;
                        r.ok = 1'b1;
                    end
                OP_DELETE:
                    if (p < used)
                    begin
                        for (i = p + 1; i < used; i++)
                            cells[i-1] = cells[i];
                        used--;
                        r.ok = 1'b1;
                    end
                OP_GET:
                    if (p < used)
                    begin
                        r.read_value = cells[p];
                        r.ok         = 1'b1;
                    end
                default: ;
            endcase
            r.count = used[CNT_W-1:0];
            r.empty = (used == 0);
            r.full  = (used == DEPTH);
            pending_outcomes.push_back(r);
        endfunction

        function void compare(string field, logic [VAL_W-1:0] exp_v,
                              logic [VAL_W-1:0] act_v);
            if (act_v !== exp_v)
            begin
                $display("%0t: %s mismatch, expected %0h, got %0h",
                         $time, field, exp_v, act_v);
                errors++;
            end
        endfunction

        // match one result strobe against the oldest prediction
        function void check_result(logic ok_a, logic signed [VAL_W-1:0] rd_a,
                                   logic [CNT_W-1:0] cnt_a, logic empty_a,
                                   logic full_a);
            outcome_t r;
            if (pending_outcomes.size() == 0)
            begin
                $display("%0t: result with no item outstanding, expected none, got ok=%0b count=%0d",
                         $time, ok_a, cnt_a);
                errors++;
            end
            else
            begin
                r = pending_outcomes.pop_front();
                compare("ok", r.ok, ok_a);
                compare("read_value", r.read_value, rd_a);
                compare("count", r.count, cnt_a);
                compare("empty_res", r.empty, empty_a);
                compare("full_res", r.full, full_a);
            end
        endfunction

        function int pending();
            return pending_outcomes.size();
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    logic [OP_W-1:0]         op;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
    logic                    done;
    logic                    ok;
    logic signed [VAL_W-1:0] read_value;
    logic [CNT_W-1:0]        count;
    logic                    empty_res;
    logic                    full_res;

    list_mirror sb = new();

    positional_list_insert_delete DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .op         (op),
        .position   (position),
        .value      (value),
        .done       (done),
        .ok         (ok),
        .read_value (read_value),
        .count      (count),
        .empty_res  (empty_res),
        .full_res   (full_res)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
            sb.check_result(ok, read_value, count, empty_res, full_res);
    end

    // present one item and hold it until the block takes it
    task automatic send_item(input logic [OP_W-1:0] o, input logic [POS_W-1:0] p,
                             input logic signed [VAL_W-1:0] v);
        @(negedge clk);
        start    <= 1'b1;
        op       <= o;
        position <= p;
        value    <= v;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        sb.note_item(o, p, v);
    endtask

    // drop start with junk on the item fields
    task automatic hold_off(input int n);
        @(negedge clk);
        start    <= 1'b0;
        op       <= OP_W'($urandom);
        position <= POS_W'($urandom);
        value    <= VAL_W'($urandom);
        repeat (n - 1)
            @(negedge clk);
    endtask

    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 19))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2:       return '0;
            3:       return VAL_NEG1;
            default: return VAL_W'($urandom);
        endcase
    endfunction

    // mostly legal positions for the current fill, sometimes anything
    function automatic logic [POS_W-1:0] pick_position(logic [OP_W-1:0] o);
        int unsigned n;
        n = sb.used;
        if ($urandom_range(0, 99) < 15)
            return POS_W'($urandom_range(0, (1 << POS_W) - 1));
        if (o == OP_INSERT)
            return POS_W'($urandom_range(0, n));
        if (n == 0)
            return '0;
        return POS_W'($urandom_range(0, n - 1));
    endfunction

    // random items in bursts, insert_pct steers the fill level
    task automatic run_phase(input int n, input int insert_pct);
        int               sent;
        int               burst;
        int               r;
        logic [OP_W-1:0]  o;
        sent = 0;
        while (sent < n)
        begin
            burst = $urandom_range(1, 20);
            for (int j = 0; j < burst && sent < n; j++)
            begin
                r = $urandom_range(0, 99);
                if (r < 3)
                    o = OP_UNUSED;
                else if (r < 3 + insert_pct * 97 / 100)
                    o = OP_INSERT;
                else if ($urandom_range(0, 1) == 0)
                    o = OP_DELETE;
                else
                    o = OP_GET;
                send_item(o, pick_position(o), pick_value());
                sent++;
            end
            if ($urandom_range(0, 3) != 0)
                hold_off($urandom_range(1, 5));
        end
    endtask

    // main sequence
    initial
    begin
        int unsigned fill_bias [7] = '{80, 20, 50, 85, 10, 50, 70};
        start    = 1'b0;
        op       = '0;
        position = '0;
        value    = '0;
        rst_n    = 1'b0;
        repeat (10)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        hold_off(2);

        // empty list rejects, unused op
        send_item(OP_GET, 5'd0, 32'sd0);
        send_item(OP_DELETE, 5'd0, 32'sd0);
        send_item(OP_INSERT, 5'd1, 32'sd7);
        send_item(OP_UNUSED, 5'd0, 32'sd9);
        // append, insert at front, append at count, insert in the middle
        send_item(OP_INSERT, 5'd0, VAL_MAX);
        send_item(OP_INSERT, 5'd0, VAL_MIN);
        send_item(OP_INSERT, 5'd2, 32'sd0);
        send_item(OP_INSERT, 5'd1, VAL_NEG1);
        // reads at both ends, then out-of-range reads, inserts and deletes
        send_item(OP_GET, 5'd0, 32'sd0);
        send_item(OP_GET, 5'd3, 32'sd0);
        send_item(OP_GET, 5'd4, 32'sd0);
        send_item(OP_GET, 5'd31, 32'sd0);
        send_item(OP_INSERT, 5'd31, 32'sd3);
        send_item(OP_INSERT, 5'd5, 32'sd3);
        send_item(OP_DELETE, 5'd31, 32'sd0);
        send_item(OP_DELETE, 5'd4, 32'sd0);
        // delete from middle, end and front down to empty
        send_item(OP_DELETE, 5'd1, 32'sd0);
        send_item(OP_DELETE, 5'd2, 32'sd0);
        send_item(OP_UNUSED, 5'd16, VAL_NEG1);
        send_item(OP_DELETE, 5'd0, 32'sd0);
        send_item(OP_GET, 5'd0, 32'sd0);
        send_item(OP_DELETE, 5'd0, 32'sd0);
        send_item(OP_GET, 5'd0, 32'sd0);

        // random phases that fill, drain and churn the list
        foreach (fill_bias[k])
            run_phase(ITEMS_PER_PHASE, fill_bias[k]);

        @(negedge clk);
        start <= 1'b0;

        // drain outstanding results
        for (int i = 0; i < 200 && sb.pending() > 0; i++)
            @(posedge clk);
        repeat (5)
            @(posedge clk);

        if (sb.pending() > 0)
            $display("%0t: results missing, expected %0d more, got 0",
                     $time, sb.pending());
        if (sb.errors == 0 && sb.pending() == 0)
            $display("positional_list_insert_delete_tb passed");
        else
            $display("positional_list_insert_delete_tb failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("positional_list_insert_delete_tb failed");
        $finish;
    end

endmodule
